// ===== rtl/dfq_pkg.sv =====
// ----------------------------------------------------------------------------
// dfq_pkg: shared definitions for the deduplicating FIFO queue
// Depth, widths, operation and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 5;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      logic load;   // capture the request word
      logic shift;  // take the word of the next cell toward the tail
      logic held;   // cell lies inside the occupied region
   } cell_ctrl_type;

endpackage

// ===== rtl/dfq_cell.sv =====
// ----------------------------------------------------------------------------
// dfq_cell: one storage cell of the queue chain
// Holds one word, loads a new word or takes its tail-side neighbor's word,
// and compares its word against the request word.
// ----------------------------------------------------------------------------
module dfq_cell (
   input  logic                   clock,
   input  dfq_pkg::cell_ctrl_type ctrl,
   input  dfq_pkg::word_type      req_word,
   input  dfq_pkg::word_type      next_word,
   output dfq_pkg::word_type      word,
   output logic                   match
);
   import dfq_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = req_word;
      end else if (ctrl.shift) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = ctrl.held && (word_ff == req_word);

endmodule

// ===== rtl/dedup_fifo_queue_top.sv =====
// ----------------------------------------------------------------------------
// dedup_fifo_queue_top: FIFO queue of signed words that rejects duplicates
//
// Request channel (req_valid/req_ready) carries an operation code and a word:
// enqueue, dequeue or peek at the front. Every request beat yields exactly one
// response beat (rsp_valid/rsp_ready) with a status, the front word for an ok
// dequeue or peek (else zero), and the occupancy after the operation.
// Entries live in a chain of cells with the front in cell 0; every cell
// compares its word with the request word in parallel, a dequeue shifts the
// chain one cell toward the front, and an enqueue loads the cell at the fill
// count. The response is valid in the cycle after the request beat; one request
// is taken per cycle while the response register is empty or being taken.
// The response sits in an output register; a new request is taken in the same
// cycle the held response is taken, so a stalled receiver holds off requests
// only while the response register is full. Reset is synchronous, active high,
// empties the queue and drops any pending response; no clearing pass runs.
// ----------------------------------------------------------------------------
module dedup_fifo_queue_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dfq_pkg::OP_W-1:0]          req_op,
   input  logic signed [dfq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dfq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [dfq_pkg::DATA_W-1:0] rsp_data_out,
   output logic [dfq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import dfq_pkg::*;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   word_type            data_ff;
   word_type            data_in;
   logic [OCC_W-1:0]    occ_ff;

   logic                req_fire;
   logic                dup_hit;
   logic                enq_ok;
   logic                deq_ok;
   word_type            cell_word  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_match;
   cell_ctrl_type       cell_ctrl  [QUEUE_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign dup_hit   = |cell_match;

   always_comb begin
      status_in = ST_OK;
      data_in   = '0;
      count_in  = count_ff;
      enq_ok    = 1'b0;
      deq_ok    = 1'b0;
      unique case (req_op) inside
         OP_ENQ: begin
            if (dup_hit) begin
               status_in = ST_DUP;
            end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               enq_ok   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DEQ, OP_PEEK: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               data_in = cell_word[0];
               if (req_op == OP_DEQ) begin
                  deq_ok   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            // unused code: no operation
         end
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         word_type next_word;

         assign cell_ctrl[g].load  = req_fire && enq_ok && (count_ff == CNT_W'(g));
         assign cell_ctrl[g].shift = req_fire && deq_ok;
         assign cell_ctrl[g].held  = CNT_W'(g) < count_ff;

         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign next_word = cell_word[g];
         end else begin : g_mid
            assign next_word = cell_word[g+1];
         end

         dfq_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .req_word  (req_value),
            .next_word (next_word),
            .word      (cell_word[g]),
            .match     (cell_match[g])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload: hold until the next request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_data_out  = data_ff;
   assign rsp_occupancy = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count above queue depth");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && enq_ok |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted enqueue did not grow the queue");

   a_dup_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_DUP |-> occ_ff != '0)
      else $error("duplicate reported on an empty queue");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_EMPTY |-> occ_ff == '0 && data_ff == '0)
      else $error("empty status with nonzero occupancy or data");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while a response is stalled");

endmodule
